// File: src/wds_pkg.sv
// ----------------------------------------------------------------------------
// wds_pkg
// Types and constants shared by the worker dispatch selector.
// ----------------------------------------------------------------------------
package wds_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned WID_W   = 5;

    localparam int unsigned MAX_WORKERS = 32;

    localparam logic [MODE_W-1:0] MODE_ROUND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_KEY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UID   = 3'd3;

    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_UPDATE   = 1'b1;

    localparam logic [0:0] REG_MODE  = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_DENY,
        ST_OUT
    } back_state_t;

    // queue entry from the front part
    typedef struct packed {
        logic              update;
        logic              preempt;
        logic              use_round;
        logic [WORD_W-1:0] value;
        logic [WID_W-1:0]  index;
        logic              idle;
        logic              deny;
    } job_t;

endpackage

// File: src/wds_front.sv
// ----------------------------------------------------------------------------
// wds_front
// Accepts input transfers, picks the hash source and queues a job.
// ----------------------------------------------------------------------------
module wds_front
    import wds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] mode,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [WORD_W-1:0] req_key,
    input  logic              conn_found,
    input  logic              conn_is_ipv4_tcp,
    input  logic [WORD_W-1:0] ipv4_address,
    input  logic [WORD_W-1:0] ipv6_last_word,
    input  logic [WORD_W-1:0] user_id,
    input  logic [WID_W-1:0]  worker_index,
    input  logic              worker_idle,
    input  logic              worker_deny,
    output logic              job_valid,
    input  logic              job_take,
    output job_t              job
);

    localparam int unsigned DEPTH = 2;

    job_t       q_reg [DEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    job_t       cls;
    logic       push, pop;

    always_comb
    begin
        cls.update    = (cmd == CMD_UPDATE);
        cls.preempt   = 1'b0;
        cls.use_round = 1'b0;
        cls.value     = req_key;
        cls.index     = worker_index;
        cls.idle      = worker_idle;
        cls.deny      = worker_deny;
        case (mode)
            MODE_ROUND: cls.use_round = 1'b1;
            MODE_KEY:   cls.value = req_key;
            MODE_IP:
            begin
                if (conn_found)
                    cls.value = conn_is_ipv4_tcp ? ipv4_address : ipv6_last_word;
            end
            MODE_UID:
            begin
                if (conn_found && user_id != '0)
                    cls.value = user_id;
            end
            default:    cls.preempt = 1'b1;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'(DEPTH));
    assign push      = in_valid && !in_stall;
    assign job_valid = (cnt_reg != '0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: src/wds_back.sv
// ----------------------------------------------------------------------------
// wds_back
// Carries out jobs: serial modulo, idle probing, deny skip, flag store.
// ----------------------------------------------------------------------------
module wds_back
    import wds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] count,
    input  logic               job_valid,
    output logic               job_take,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WID_W-1:0]   chosen_worker,
    output logic               busy
);

    localparam int unsigned CNT_MAX = (MAX_WORKERS < 32) ? MAX_WORKERS : 32;
    localparam int unsigned FL_W = MAX_WORKERS;
    localparam int unsigned BIT_W = $clog2(WORD_W + 1);

    back_state_t        state_reg, state_next;
    logic [WORD_W-1:0]  round_reg;
    logic [FL_W-1:0]    idle_reg, deny_reg;
    logic [WORD_W-1:0]  dvd_reg;
    logic [COUNT_W:0]   rem_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               preempt_reg;
    logic [COUNT_W-1:0] probe_reg, step_reg;
    logic [WID_W-1:0]   tgt_reg;
    logic [WID_W-1:0]   res_reg;
    logic               res_valid_reg;
    logic [COUNT_W-1:0] n;
    logic [COUNT_W:0]   rem_sh;
    logic               at_top;
    logic               probe_done;
    logic               res_load;

    always_comb
    begin
        n = count;
        if (n == '0)
            n = COUNT_W'(1);
        if (n > COUNT_W'(CNT_MAX))
            n = COUNT_W'(CNT_MAX);
    end

    assign rem_sh   = {rem_reg[COUNT_W-1:0], dvd_reg[WORD_W-1]};
    assign at_top   = (COUNT_W'(tgt_reg) + 1'b1 == n);
    // up to n+1 probes, n being count clamped to 1..32
    assign probe_done = idle_reg[tgt_reg] || (probe_reg == n + COUNT_W'(1));
    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || !out_stall);
    assign job_take = (state_reg == ST_IDLE) && job_valid;
    assign busy     = (state_reg != ST_IDLE) || job_valid;
    assign out_valid = res_valid_reg;
    assign chosen_worker = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (job_valid && !job.update)
                    state_next = ST_MOD;
            ST_MOD:
                if (bit_reg == BIT_W'(WORD_W - 1))
                    state_next = preempt_reg ? ST_PROBE : ST_DENY;
            ST_PROBE:
                state_next = probe_done ? ST_DENY : ST_MOD;
            ST_DENY:
                if (!deny_reg[tgt_reg] || step_reg == n)
                    state_next = ST_OUT;
            ST_OUT:
                if (!res_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            idle_reg      <= '1;
            deny_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_load || (res_valid_reg && out_stall);
            case (state_reg)
                ST_IDLE:
                    if (job_take)
                    begin
                        if (job.update)
                        begin
                            if (32'(job.index) < MAX_WORKERS)
                            begin
                                idle_reg[job.index] <= job.idle;
                                deny_reg[job.index] <= job.deny;
                            end
                        end
                        else if (job.use_round || job.preempt)
                            round_reg <= round_reg + 1'b1;
                    end
                ST_PROBE:
                    if (!probe_done)
                        round_reg <= round_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dvd_reg     <= (job.use_round || job.preempt) ? round_reg : job.value;
                preempt_reg <= job.preempt;
                rem_reg     <= '0;
                bit_reg     <= '0;
                probe_reg   <= '0;
                step_reg    <= '0;
            end
            ST_MOD:
            begin
                dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
                bit_reg <= bit_reg + 1'b1;
                if (rem_sh >= {1'b0, n})
                    rem_reg <= rem_sh - {1'b0, n};
                else
                    rem_reg <= rem_sh;
                if (bit_reg == BIT_W'(WORD_W - 1))
                begin
                    tgt_reg   <= WID_W'((rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh);
                    probe_reg <= probe_reg + 1'b1;
                end
            end
            ST_PROBE:
            begin
                dvd_reg <= round_reg;
                rem_reg <= '0;
                bit_reg <= '0;
            end
            ST_DENY:
                if (deny_reg[tgt_reg])
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == n)
                        tgt_reg <= '0;
                    else
                        tgt_reg <= at_top ? '0 : tgt_reg + 1'b1;
                end
            ST_OUT:
                if (!res_valid_reg || !out_stall)
                    res_reg <= tgt_reg;
            default: ;
        endcase
    end

endmodule

// File: src/worker_dispatch_selector.sv
// ----------------------------------------------------------------------------
// worker_dispatch_selector
// Chooses an event worker per dispatch request; keeps idle and deny flags.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// input     | in_valid/in_stall  | cmd .. worker_deny
// output    | out_valid/out_stall| chosen_worker
// config    | APB write/read     | mode, worker_count
// A flag update is stored as the back part takes it. A dispatch holds the back
// part through the bit-serial remainder unit (one dividend bit a cycle); in
// preemptive mode, a probe and a new remainder for each worker found not idle;
// then a skip past denied workers and the output.
// Reset sets the idle flags, clears the deny flags, counter and queue at once. A
// two-entry queue lets the front keep taking transfers while the back waits on out_stall.
// ----------------------------------------------------------------------------
module worker_dispatch_selector
    import wds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [WORD_W-1:0] req_key,
    input  logic              conn_found,
    input  logic              conn_is_ipv4_tcp,
    input  logic [WORD_W-1:0] ipv4_address,
    input  logic [WORD_W-1:0] ipv6_last_word,
    input  logic [WORD_W-1:0] user_id,
    input  logic [WID_W-1:0]  worker_index,
    input  logic              worker_idle,
    input  logic              worker_deny,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WID_W-1:0]  chosen_worker
);

    logic [MODE_W-1:0]  mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               job_valid, job_take, busy;
    job_t               job;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_KEY;
            count_reg <= COUNT_W'(1);
        end
        else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_MODE)
            mode_reg <= pwdata[MODE_W-1:0];
        else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_COUNT)
            count_reg <= pwdata[COUNT_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                REG_MODE:  prdata = 32'(mode_reg);
                REG_COUNT: prdata = 32'(count_reg);
                default:   prdata = '0;
            endcase
        end
    end

    wds_front u_front (
        .clk, .rst_n, .mode(mode_reg), .in_valid, .in_stall, .cmd, .req_key,
        .conn_found, .conn_is_ipv4_tcp, .ipv4_address, .ipv6_last_word, .user_id,
        .worker_index, .worker_idle, .worker_deny, .job_valid, .job_take, .job
    );

    wds_back u_back (
        .clk, .rst_n, .count(count_reg), .job_valid, .job_take, .job,
        .out_valid, .out_stall, .chosen_worker, .busy
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_worker))
        else $error("result dropped under stall");
    a_take_queued: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid)
        else $error("job taken from empty queue");
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> busy)
        else $error("accepted transfer not tracked");

endmodule
